@@ src/firc_pkg.sv @@
package firc_pkg;

    // Default history / coefficient depth.
    localparam int MAX_TAPS_DEF = 64;

    // Word field widths.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int CIDX_W   = 6;
    localparam int TAPCNT_W = 7;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = 40;

    // Command codes.
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // 1.0 in Q2.14, reset value of tap 0.
    localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;

    // Right shift for the rounded Q3.29 -> Q1.15 conversion.
    localparam int RND_SHIFT = 14;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CIDX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } firc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } firc_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } firc_state_t;

endpackage

@@ src/fir_filter_circular.sv @@
// Direct-form FIR filter, Q1.15 samples times Q2.14 coefficients, over a
// circular history of MAX_TAPS samples. A filter word (cmd = CMD_FILTER) is
// stored at the write position and answered by one output word: the sum of
// coefficient j times the sample j steps back, over tap_count taps, kept in
// a 40-bit accumulator, rounded half up to Q1.15 and saturated (saturated
// flags a clip). A load word (cmd = CMD_LOAD) writes one coefficient, clears
// the history and the write position, and gives no output; indexes at or
// above MAX_TAPS write nothing. One shared 16x16 multiplier and a 40-bit
// adder do one tap per cycle; the output register is loaded once the last
// tap is summed and the register is empty or being read. A load word leaves
// the sequencer idle. req_ready is high only while the sequencer is idle;
// a finished output waits in its own register, so a new word can be taken
// before it is collected. After reset a clearing pass writes the
// coefficient memory (tap 0 = 1.0, others 0), with req_ready low; cfg
// writes to tap_count are taken at any time and do not disturb the history.
// tap_count of 0 acts as 1, above MAX_TAPS as MAX_TAPS.
module fir_filter_circular #(
    parameter int MAX_TAPS = firc_pkg::MAX_TAPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  firc_pkg::firc_in_t              req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output firc_pkg::firc_out_t             rsp,
    input  logic                            cfg_we,
    input  logic [firc_pkg::TAPCNT_W-1:0]   cfg_wdata
);

    import firc_pkg::*;

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [AW:0]   FILL_FULL = (AW + 1)'(MAX_TAPS);

    // ---------------- state ----------------
    firc_state_t           state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;       // clearing pass address
    logic [AW-1:0]         wpos_reg, wpos_next;     // history write position
    logic [AW:0]           fill_reg, fill_next;     // history entries written since clear
    logic [AW-1:0]         last_reg, last_next;     // last tap index of this word
    logic [AW-1:0]         tap_reg, tap_next;       // tap being issued
    logic [AW-1:0]         idx_reg, idx_next;       // history slot being issued
    logic                  rd_vld_reg, rd_vld_next; // RAM data arriving
    logic                  hv_reg, hv_next;         // history slot holds a live sample
    logic                  prod_vld_reg, prod_vld_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [TAPCNT_W-1:0]   tap_count_reg, tap_count_next;
    firc_out_t             rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // ---------------- memories ----------------
    logic                  coef_we;
    logic [AW-1:0]         coef_waddr;
    logic [COEF_W-1:0]     coef_wdata;
    logic [COEF_W-1:0]     coef_rdata;
    logic                  hist_we;
    logic [AW-1:0]         hist_waddr;
    logic [SAMPLE_W-1:0]   hist_wdata;
    logic [SAMPLE_W-1:0]   hist_rdata;

    firc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (tap_reg),
        .rdata (coef_rdata)
    );

    firc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (idx_reg),
        .rdata (hist_rdata)
    );

    // ---------------- helpers ----------------
    logic                    accept;
    logic                    rsp_free;
    logic [31:0]             taps_w;
    logic                    cidx_ok;
    logic signed [SAMPLE_W-1:0] hist_q;
    logic signed [ACC_W:0]   rnd_sum;
    logic signed [ACC_W-RND_SHIFT:0] rnd_q;
    firc_out_t               rnd_word;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Effective tap count clamped to 1..MAX_TAPS.
    always_comb
    begin
        taps_w = {{(32 - TAPCNT_W){1'b0}}, tap_count_reg};
        if (taps_w == 32'd0)
        begin
            taps_w = 32'd1;
        end
        else if (taps_w > 32'(MAX_TAPS))
        begin
            taps_w = 32'(MAX_TAPS);
        end
    end

    assign cidx_ok = ({{(32 - CIDX_W){1'b0}}, req.coef_index} < 32'(MAX_TAPS));

    // Slots not written since the last clear read as zero.
    assign hist_q = hv_reg ? $signed(hist_rdata) : '0;

    // Round half up, floor shift, saturate.
    always_comb
    begin
        rnd_sum = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W + 1)'(1 << (RND_SHIFT - 1));
        rnd_q   = rnd_sum[ACC_W:RND_SHIFT];
        rnd_word.saturated = 1'b1;
        if (rnd_q > (ACC_W - RND_SHIFT + 1)'(32767))
        begin
            rnd_word.sample_out = 16'sh7FFF;
        end
        else if (rnd_q < -(ACC_W - RND_SHIFT + 1)'(32768))
        begin
            rnd_word.sample_out = 16'sh8000;
        end
        else
        begin
            rnd_word.sample_out = rnd_q[SAMPLE_W-1:0];
            rnd_word.saturated  = 1'b0;
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (req.cmd == CMD_FILTER))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (tap_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        clr_next       = clr_reg;
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        last_next      = last_reg;
        tap_next       = tap_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        hv_next        = hv_reg;
        prod_vld_next  = rd_vld_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        tap_count_next = cfg_we ? cfg_wdata : tap_count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        coef_we    = 1'b0;
        coef_waddr = clr_reg;
        coef_wdata = '0;
        hist_we    = 1'b0;
        hist_waddr = wpos_reg;
        hist_wdata = req.sample_in;

        // multiply stage
        if (rd_vld_reg)
        begin
            prod_next = $signed(coef_rdata) * hist_q;
        end
        // accumulate stage, 40-bit wrap
        if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end

        unique case (state_reg)
            ST_INIT:
            begin
                coef_we    = 1'b1;
                coef_waddr = clr_reg;
                coef_wdata = (clr_reg == '0) ? COEF_ONE : '0;
                clr_next   = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_LOAD)
                    begin
                        coef_we    = cidx_ok;
                        coef_waddr = AW'({{(32 - CIDX_W){1'b0}}, req.coef_index});
                        coef_wdata = req.coef_value;
                        wpos_next  = '0;
                        fill_next  = '0;
                    end
                    else
                    begin
                        hist_we   = 1'b1;
                        wpos_next = (wpos_reg == LAST_ADDR) ? '0 : wpos_reg + AW'(1);
                        if (fill_reg != FILL_FULL)
                        begin
                            fill_next = fill_reg + (AW + 1)'(1);
                        end
                        last_next = AW'(taps_w - 32'd1);
                        tap_next  = '0;
                        idx_next  = wpos_reg;
                        acc_next  = '0;
                    end
                end
            end
            ST_MAC:
            begin
                // issue one tap: coefficient j, sample j steps back
                rd_vld_next = 1'b1;
                hv_next     = ({1'b0, idx_reg} < fill_reg);
                tap_next    = tap_reg + AW'(1);
                idx_next    = (idx_reg == '0) ? LAST_ADDR : idx_reg - AW'(1);
            end
            ST_DRAIN:
            begin
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next       = rnd_word;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_reg       <= '0;
            wpos_reg      <= '0;
            fill_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            tap_count_reg <= TAPCNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            rd_vld_reg    <= rd_vld_next;
            prod_vld_reg  <= prod_vld_next;
            tap_count_reg <= tap_count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        tap_reg  <= tap_next;
        idx_reg  <= idx_next;
        hv_reg   <= hv_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rsp_reg  <= rsp_next;
    end

endmodule

@@ src/firc_ram.sv @@
module firc_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
